// ===== rtl/core/kscp_pkg.sv =====
`timescale 1ns / 1ps

package kscp_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // bytes pushed for one key press
  localparam int PRESS_BYTES = 6;
  localparam int PUSH_CNT_W  = $clog2(PRESS_BYTES);

  // bus constants
  localparam logic [3:0] CMD_ADDR  = 4'h4;
  localparam logic [7:0] CMD_RESET = 8'h9F;
  localparam logic [7:0] ANS_RESET = 8'h80;
  localparam logic [7:0] ANS_IDLE  = 8'hFF;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_PRESS = 2'd2,
    ACT_NONE  = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    MODE_RESET    = 2'd0,
    MODE_ANNOUNCE = 2'd1,
    MODE_REPORT   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    SEL_ROW = 2'd0,
    SEL_COL = 2'd1,
    SEL_MOD = 2'd2
  } byte_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_PUSH = 2'd2
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic      capture;
    logic      exec;
    logic      push;
    logic      push_last;
    byte_sel_e byte_sel;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_press;
    logic room_ok;
  } dp_status_t;

endpackage

// ===== rtl/core/kscp_ctrl.sv =====
`timescale 1ns / 1ps

module kscp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  kscp_pkg::dp_status_t status_i,
  output kscp_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);
  import kscp_pkg::*;

  state_e                state_q, state_d;
  logic [PUSH_CNT_W-1:0] cnt_q, cnt_d;
  logic                  cnt_last;

  assign cnt_last = (cnt_q == PUSH_CNT_W'(PRESS_BYTES - 1));

  // state and push counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (start_i) begin
          if (status_i.is_press && status_i.room_ok) begin
            state_d = ST_PUSH;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      ST_PUSH: begin
        if (cnt_last) begin
          state_d = ST_IDLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.byte_sel  = SEL_ROW;
    busy_o          = (state_q != ST_IDLE);
    cmd_o.capture   = (state_q == ST_IDLE) && start_i;
    cmd_o.exec      = (state_q == ST_EXEC);
    cmd_o.push      = (state_q == ST_PUSH);
    cmd_o.push_last = (state_q == ST_PUSH) && cnt_last;
    // row, column, modifier, then again
    case (cnt_q)
      PUSH_CNT_W'(0), PUSH_CNT_W'(3): cmd_o.byte_sel = SEL_ROW;
      PUSH_CNT_W'(1), PUSH_CNT_W'(4): cmd_o.byte_sel = SEL_COL;
      default:                        cmd_o.byte_sel = SEL_MOD;
    endcase
  end

endmodule

// ===== rtl/core/kscp_dp.sv =====
`timescale 1ns / 1ps

module kscp_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kscp_pkg::ctrl_cmd_t  cmd_i,
  output kscp_pkg::dp_status_t status_o,
  input  logic [1:0]           action_i,
  input  logic [3:0]           address_i,
  input  logic [7:0]           value_i,
  input  logic [7:0]           key_row_i,
  input  logic [7:0]           key_column_i,
  input  logic [7:0]           key_modifier_i,
  output logic                 done_o,
  output logic [7:0]           read_data_o,
  output logic                 key_dropped_o
);
  import kscp_pkg::*;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(QUEUE_DEPTH - PRESS_BYTES);

  // byte queue storage
  logic [7:0] mem_q [QUEUE_DEPTH];
  logic [7:0] front_q;

  // captured word
  act_e       act_q;
  logic [3:0] addr_q;
  logic [7:0] value_q, row_q, col_q, mod_q;

  // port state
  mode_e            mode_q, mode_d;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       mask_q, mask_d;
  logic [PTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [1:0]       mod3_q, mod3_d;

  // result registers
  logic       done_q;
  logic [7:0] rdata_q, rdata_d;
  logic       drop_q;

  logic [7:0] push_byte;
  logic       pop;

  assign status_o.is_press = (act_e'(action_i) == ACT_PRESS);
  assign status_o.room_ok  = (count_q <= ROOM_MAX);

  // byte chosen for this push cycle
  always_comb begin
    case (cmd_i.byte_sel)
      SEL_ROW: push_byte = row_q;
      SEL_COL: push_byte = col_q;
      default: push_byte = mod_q;
    endcase
  end

  // queue memory, registered read at the head
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[tail_q] <= push_byte;
    end
    front_q <= mem_q[head_q];
  end

  // capture the accepted word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= act_e'(action_i);
      addr_q  <= address_i;
      value_q <= value_i;
      row_q   <= key_row_i;
      col_q   <= key_column_i;
      mod_q   <= key_modifier_i;
    end
  end

  // bus read / write and push handling
  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    mask_d  = mask_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    mod3_d  = mod3_q;
    rdata_d = '0;
    pop     = 1'b0;

    if (cmd_i.exec) begin
      if (act_q == ACT_READ) begin
        if (addr_q == CMD_ADDR) begin
          rdata_d = ANS_IDLE;
        end else if (mode_q == MODE_RESET) begin
          rdata_d = ANS_RESET;
        end else if (mode_q == MODE_ANNOUNCE) begin
          if (count_q == '0) begin
            rdata_d = ANS_IDLE;
          end else begin
            mode_d = MODE_REPORT;
          end
        end else if (phase_q != 2'd1) begin
          // compare step
          if (count_q == '0) begin
            rdata_d = ANS_IDLE;
          end else if ((mask_q & front_q) == front_q) begin
            rdata_d = ANS_IDLE;
          end else begin
            pop = 1'b1;
            if (mod3_q == 2'd1) begin
              mode_d = MODE_ANNOUNCE;
            end
          end
        end else begin
          // data byte step
          if (count_q != '0) begin
            rdata_d = front_q;
            pop     = 1'b1;
          end
        end
      end else if (act_q == ACT_WRITE) begin
        if (addr_q == CMD_ADDR) begin
          if (value_q == CMD_RESET) begin
            mode_d = MODE_RESET;
          end else if (value_q == 8'h00 && mod3_q == 2'd0 && mode_q != MODE_REPORT) begin
            mode_d  = MODE_ANNOUNCE;
            phase_d = 2'd0;
          end else begin
            mode_d = MODE_REPORT;
            mask_d = value_q;
          end
        end
      end
    end

    if (pop) begin
      head_d  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
      mod3_d  = (mod3_q == 2'd0) ? 2'd2 : mod3_q - 2'd1;
      phase_d = (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
    end

    if (cmd_i.push) begin
      tail_d  = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
      mod3_d  = (mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1;
    end
  end

  // port state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_RESET;
      phase_q <= '0;
      mask_q  <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      mod3_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      mask_q  <= mask_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      mod3_q  <= mod3_d;
      done_q  <= cmd_i.exec | cmd_i.push_last;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec | cmd_i.push_last) begin
      rdata_q <= rdata_d;
      drop_q  <= cmd_i.exec && (act_q == ACT_PRESS);
    end
  end

  assign done_o        = done_q;
  assign read_data_o   = rdata_q;
  assign key_dropped_o = drop_q;

endmodule

// ===== rtl/core/keyboard_scan_code_port_unit.sv =====
`timescale 1ns / 1ps
// keyboard scan code port
// command channel: a word (action, address, value, key bytes) is taken at a
// rising edge with start_i high and busy_o low. busy_o stays high while the
// word is worked on.
// result channel: done_o is high for exactly one cycle with read_data_o and
// key_dropped_o valid; the receiver must take it then, it cannot stall.
// flow: a bus read, bus write, ignored action or dropped key press passes
// through the exec state and gives its result from the done register.
// a key press that fits pushes six bytes into the queue, one per cycle
// through the single write port of the queue memory; its result
// comes from the done register, set by the last push.
// the front byte comes from a registered read of the queue memory at the
// head pointer, fetched in the cycle the word is accepted.
// reset: mode returns to reset mode, queue empty, phase and mask cleared;
// queue contents are not cleared and are read only once written.
// a new word may be accepted in the cycle its predecessor's result shows.

module keyboard_scan_code_port_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] action_i,
  input  logic [3:0] address_i,
  input  logic [7:0] value_i,
  input  logic [7:0] key_row_i,
  input  logic [7:0] key_column_i,
  input  logic [7:0] key_modifier_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic       key_dropped_o
);
  import kscp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer
  kscp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // queue and port state
  kscp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .action_i       (action_i),
    .address_i      (address_i),
    .value_i        (value_i),
    .key_row_i      (key_row_i),
    .key_column_i   (key_column_i),
    .key_modifier_i (key_modifier_i),
    .done_o         (done_o),
    .read_data_o    (read_data_o),
    .key_dropped_o  (key_dropped_o)
  );

endmodule
